// ----- src/dda_line_color_interpolator_top_defines.svh -----
// Assertion macros used by the line interpolator controller.
`ifndef DDA_LINE_COLOR_INTERPOLATOR_TOP_DEFINES_SVH
`define DDA_LINE_COLOR_INTERPOLATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLCI_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLCI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dlci_pkg.sv -----
`timescale 1ns / 1ps
package dlci_pkg;

	localparam int COORD_W = 16;
	localparam int CHAN_W = 8;
	localparam int COLOR_W = 24;
	localparam int LEN_FRAC = 15;
	localparam int DIFF_W = 17;
	localparam int SQ_W = 34;
	localparam int RAD_W = 64;
	localparam int ROOT_BITS = 32;
	localparam int SREM_W = 34;
	localparam int STEPS_W = 17;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 56;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef enum logic [2:0] {
		SEL_X,
		SEL_Y,
		SEL_R,
		SEL_G,
		SEL_B
	} sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_LEN,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_DIV_STORE
	} state_t;

	typedef struct packed {
		logic load;
		logic sq_x;
		logic sq_y;
		logic sqrt_step;
		logic set_len;
		logic div_init;
		logic div_step;
		logic div_store;
		logic pix_step;
		sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic s_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ----- src/dda_line_color_interpolator_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Fields
// s_axis    in   tuser: req_type; tdata: start_x, start_y, end_x, end_y,
//                start_red, start_green, start_blue, end_red, end_green, end_blue
// m_axis    out  tuser: visible; tlast: last_pixel; tdata: pixel_x, pixel_y, pixel_color
//
// Pixels stream at one per cycle while m_axis takes them; a load holds s_axis_tready low.
// A load request runs the two squares, the square root and then the shared divider
// for x, y, red, green and blue in turn; the divider makes one quotient bit per cycle.
// A zero-length line ends after the square root.
// Reset clears the controller and the step count; no line is active after it.
// A held pixel on m_axis stalls the input side until it is taken.
module dda_line_color_interpolator_top #(
	parameter int SCREEN_WIDTH = 1024,
	parameter int SCREEN_HEIGHT = 1024,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
	// end_red, end_green, end_blue
	input logic [dlci_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// req_type
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [dlci_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// visible
	output logic m_axis_tuser,
	output logic m_axis_tlast
);
	import dlci_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;
	logic signed [COORD_W-1:0] pixel_x, pixel_y;
	logic [COLOR_W-1:0] pixel_color;

	dlci_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_type(s_axis_tuser),
		.status(status),
		.in_ready(s_axis_tready),
		.cmd(cmd)
	);

	dlci_dp #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.start_x(s_axis_tdata[15:0]),
		.start_y(s_axis_tdata[31:16]),
		.end_x(s_axis_tdata[47:32]),
		.end_y(s_axis_tdata[63:48]),
		.start_red(s_axis_tdata[71:64]),
		.start_green(s_axis_tdata[79:72]),
		.start_blue(s_axis_tdata[87:80]),
		.end_red(s_axis_tdata[95:88]),
		.end_green(s_axis_tdata[103:96]),
		.end_blue(s_axis_tdata[111:104]),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.visible(m_axis_tuser),
		.pixel_color(pixel_color),
		.last_pixel(m_axis_tlast)
	);

	assign m_axis_tdata = {pixel_color, pixel_y, pixel_x};
endmodule

// ----- src/dlci_ctrl.sv -----
`timescale 1ns / 1ps
`include "dda_line_color_interpolator_top_defines.svh"
module dlci_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_type,
	input dlci_pkg::dp_status_t status,
	output logic in_ready,
	output dlci_pkg::dp_cmd_t cmd
);
	import dlci_pkg::*;

	localparam int NW = FRAC_BITS + LEN_FRAC + DIFF_W;
	localparam int CW = $clog2(NW);

	state_t state_q;
	state_t state_d;
	logic [CW-1:0] cnt_q;
	sel_t sel_q;
	logic sqrt_last;
	logic div_last;

	assign sqrt_last = (cnt_q == CW'(ROOT_BITS - 1));
	assign div_last = (cnt_q == CW'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			sel_q <= SEL_X;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQRT || state_q == ST_DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_LEN) begin
				sel_q <= SEL_X;
			end else if (state_q == ST_DIV_STORE) begin
				case (sel_q)
					SEL_X: sel_q <= SEL_Y;
					SEL_Y: sel_q <= SEL_R;
					SEL_R: sel_q <= SEL_G;
					SEL_G: sel_q <= SEL_B;
					default: sel_q <= SEL_X;
				endcase
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready && in_type == REQ_LOAD) begin
					state_d = ST_SQX;
				end
			end
			ST_SQX: state_d = ST_SQY;
			ST_SQY: state_d = ST_SQRT;
			ST_SQRT: begin
				if (sqrt_last) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: state_d = status.s_zero ? ST_IDLE : ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (div_last) begin
					state_d = ST_DIV_STORE;
				end
			end
			ST_DIV_STORE: state_d = (sel_q == SEL_B) ? ST_IDLE : ST_DIV_INIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = status.out_free;
				cmd.load = in_valid && status.out_free && in_type == REQ_LOAD;
				cmd.pix_step = in_valid && status.out_free && in_type == REQ_STEP;
			end
			ST_SQX: cmd.sq_x = 1'b1;
			ST_SQY: cmd.sq_y = 1'b1;
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_LEN: cmd.set_len = !status.s_zero;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV_RUN: cmd.div_step = 1'b1;
			ST_DIV_STORE: cmd.div_store = 1'b1;
			default: cmd = '0;
		endcase
	end

	`DLCI_ASSERT_SAME(a_busy_no_step, clk, arst_n, state_q != ST_IDLE, !cmd.pix_step && !in_ready, "request taken while busy")
	`DLCI_ASSERT_NEXT(a_sqrt_len, clk, arst_n, state_q == ST_SQRT && sqrt_last, state_q == ST_LEN, "square root did not end on time")
	`DLCI_ASSERT_NEXT(a_last_div, clk, arst_n, state_q == ST_DIV_STORE && sel_q == SEL_B, state_q == ST_IDLE, "divide sequence did not finish")
endmodule

// ----- src/dlci_dp.sv -----
`timescale 1ns / 1ps
module dlci_dp #(
	parameter int SCREEN_WIDTH = 1024,
	parameter int SCREEN_HEIGHT = 1024,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input dlci_pkg::dp_cmd_t cmd,
	output dlci_pkg::dp_status_t status,
	input logic signed [dlci_pkg::COORD_W-1:0] start_x,
	input logic signed [dlci_pkg::COORD_W-1:0] start_y,
	input logic signed [dlci_pkg::COORD_W-1:0] end_x,
	input logic signed [dlci_pkg::COORD_W-1:0] end_y,
	input logic [dlci_pkg::CHAN_W-1:0] start_red,
	input logic [dlci_pkg::CHAN_W-1:0] start_green,
	input logic [dlci_pkg::CHAN_W-1:0] start_blue,
	input logic [dlci_pkg::CHAN_W-1:0] end_red,
	input logic [dlci_pkg::CHAN_W-1:0] end_green,
	input logic [dlci_pkg::CHAN_W-1:0] end_blue,
	input logic out_ready,
	output logic out_valid,
	output logic signed [dlci_pkg::COORD_W-1:0] pixel_x,
	output logic signed [dlci_pkg::COORD_W-1:0] pixel_y,
	output logic visible,
	output logic [dlci_pkg::COLOR_W-1:0] pixel_color,
	output logic last_pixel
);
	import dlci_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int NW = F + LEN_FRAC + DIFF_W;
	localparam int AW = F + 17;
	localparam int CAW = F + 10;
	localparam int PIW = F + 2;
	localparam int CIW = F + 10;

	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [CHAN_W:0] dr_q, dg_q, db_q;
	logic [SQ_W-1:0] sq_q;
	logic s_zero_q;
	logic [RAD_W-1:0] rad_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_BITS-1:0] drem_q;
	logic [NW-1:0] qr_q;
	logic neg_q;
	logic signed [AW-1:0] px_acc_q, py_acc_q;
	logic signed [CAW-1:0] r_acc_q, g_acc_q, b_acc_q;
	logic signed [PIW-1:0] x_inc_q, y_inc_q;
	logic signed [CIW-1:0] r_inc_q, g_inc_q, b_inc_q;
	logic [STEPS_W-1:0] steps_q;
	logic out_valid_q;

	logic signed [2*DIFF_W-1:0] prod;
	logic signed [DIFF_W-1:0] mul_a;
	logic [SQ_W-1:0] s_sum;
	logic [SREM_W+1:0] s_t, s_trial;
	logic [ROOT_BITS:0] d_t;
	logic d_ge;
	logic signed [DIFF_W-1:0] div_d;
	logic [DIFF_W-1:0] div_mag;
	logic signed [PIW-1:0] pos_inc;
	logic signed [CIW-1:0] col_inc;
	logic emit;

	function automatic logic [COORD_W-1:0] trunc_pos(input logic signed [AW-1:0] acc);
		logic signed [AW-F-1:0] whole;
		whole = acc[AW-1:F];
		if (acc[AW-1] && (|acc[F-1:0])) begin
			whole = whole + 1'b1;
		end
		return whole[COORD_W-1:0];
	endfunction

	function automatic logic on_axis(input logic signed [AW-1:0] acc, input int lim);
		logic [AW-F-2:0] mag;
		mag = acc[AW-2:F];
		return !acc[AW-1] && (mag < (AW-F-1)'(lim));
	endfunction

	function automatic logic [CHAN_W-1:0] chan(input logic signed [CAW-1:0] acc);
		logic [CAW-F-2:0] whole;
		whole = acc[CAW-2:F];
		if (acc[CAW-1]) begin
			return '0;
		end else if (whole > (CAW-F-1)'(255)) begin
			return 8'hFF;
		end
		return whole[CHAN_W-1:0];
	endfunction

	assign mul_a = cmd.sq_x ? dx_q : dy_q;
	assign prod = mul_a * mul_a;
	assign s_sum = sq_q + SQ_W'(prod);

	assign s_t = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial = {2'b00, root_q, 2'b01};

	assign d_t = {drem_q, qr_q[NW-1]};
	assign d_ge = (d_t >= {1'b0, root_q});

	always_comb begin
		case (cmd.sel)
			SEL_X: div_d = dx_q;
			SEL_Y: div_d = dy_q;
			SEL_R: div_d = DIFF_W'(dr_q);
			SEL_G: div_d = DIFF_W'(dg_q);
			SEL_B: div_d = DIFF_W'(db_q);
			default: div_d = '0;
		endcase
	end
	assign div_mag = div_d[DIFF_W-1] ? DIFF_W'(-div_d) : div_d;

	assign pos_inc = neg_q ? -$signed({1'b0, qr_q[PIW-2:0]}) : $signed({1'b0, qr_q[PIW-2:0]});
	assign col_inc = neg_q ? -$signed({1'b0, qr_q[CIW-2:0]}) : $signed({1'b0, qr_q[CIW-2:0]});

	assign emit = cmd.pix_step && (steps_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			out_valid_q <= 1'b0;
			s_zero_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				steps_q <= '0;
			end else if (cmd.set_len) begin
				steps_q <= root_q[ROOT_BITS-1 -: STEPS_W] + STEPS_W'(srem_q != '0);
			end else if (emit) begin
				steps_q <= steps_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.sq_y) begin
				s_zero_q <= (s_sum == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= DIFF_W'(end_x) - DIFF_W'(start_x);
			dy_q <= DIFF_W'(end_y) - DIFF_W'(start_y);
			dr_q <= $signed({1'b0, end_red}) - $signed({1'b0, start_red});
			dg_q <= $signed({1'b0, end_green}) - $signed({1'b0, start_green});
			db_q <= $signed({1'b0, end_blue}) - $signed({1'b0, start_blue});
			px_acc_q <= $signed({{(AW-COORD_W-F){start_x[COORD_W-1]}}, start_x, {F{1'b0}}});
			py_acc_q <= $signed({{(AW-COORD_W-F){start_y[COORD_W-1]}}, start_y, {F{1'b0}}});
			r_acc_q <= $signed({{(CAW-CHAN_W-F){1'b0}}, start_red, {F{1'b0}}});
			g_acc_q <= $signed({{(CAW-CHAN_W-F){1'b0}}, start_green, {F{1'b0}}});
			b_acc_q <= $signed({{(CAW-CHAN_W-F){1'b0}}, start_blue, {F{1'b0}}});
		end else if (emit) begin
			px_acc_q <= px_acc_q + AW'(x_inc_q);
			py_acc_q <= py_acc_q + AW'(y_inc_q);
			r_acc_q <= r_acc_q + CAW'(r_inc_q);
			g_acc_q <= g_acc_q + CAW'(g_inc_q);
			b_acc_q <= b_acc_q + CAW'(b_inc_q);
		end
		if (emit) begin
			pixel_x <= trunc_pos(px_acc_q);
			pixel_y <= trunc_pos(py_acc_q);
			visible <= on_axis(px_acc_q, SCREEN_WIDTH) && on_axis(py_acc_q, SCREEN_HEIGHT);
			pixel_color <= {chan(r_acc_q), chan(g_acc_q), chan(b_acc_q)};
			last_pixel <= (steps_q == STEPS_W'(1));
		end
		if (cmd.sq_x) begin
			sq_q <= SQ_W'(prod);
		end
		if (cmd.sq_y) begin
			rad_q <= {s_sum[RAD_W-2*LEN_FRAC-1:0], {(2*LEN_FRAC){1'b0}}};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (s_t >= s_trial) begin
				srem_q <= SREM_W'(s_t - s_trial);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				srem_q <= s_t[SREM_W-1:0];
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			drem_q <= '0;
			qr_q <= {div_mag, {(F+LEN_FRAC){1'b0}}};
			neg_q <= div_d[DIFF_W-1];
		end else if (cmd.div_step) begin
			drem_q <= d_ge ? ROOT_BITS'(d_t - {1'b0, root_q}) : d_t[ROOT_BITS-1:0];
			qr_q <= {qr_q[NW-2:0], d_ge};
		end
		if (cmd.div_store) begin
			case (cmd.sel)
				SEL_X: x_inc_q <= pos_inc;
				SEL_Y: y_inc_q <= pos_inc;
				SEL_R: r_inc_q <= col_inc;
				SEL_G: g_inc_q <= col_inc;
				SEL_B: b_inc_q <= col_inc;
				default: x_inc_q <= x_inc_q;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status.s_zero = s_zero_q;
	assign status.out_free = !out_valid_q || out_ready;
endmodule

// ----- tb/sv/tb_dda_line_color_interpolator_top.sv -----
`timescale 1ns / 1ps
module tb_dda_line_color_interpolator_top;
	import dlci_pkg::*;

	localparam int SCR_W = 1024;
	localparam int SCR_H = 1024;
	localparam int FB = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic req;
		logic [IN_DATA_W-1:0] data;
	} line_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic vis;
		logic [COLOR_W-1:0] color;
		logic last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	dda_line_color_interpolator_top dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	line_req_t pending_reqs[$];
	pixel_t expected_pixels[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	longint pos_x, pos_y, acc_c[3], inc_x, inc_y, inc_c[3];
	longint steps_rem = 0;

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint incr_of(longint d, longint lq);
		longint q;
		q = ((d < 0 ? -d : d) << (FB + LEN_FRAC)) / lq;
		return d < 0 ? -q : q;
	endfunction

	function automatic logic [7:0] clamp_chan(longint a);
		if (a < 0) return 8'd0;
		if ((a >>> FB) > 255) return 8'd255;
		return 8'(a >>> FB);
	endfunction

	task automatic predict_pixel(line_req_t r);
		longint sx, sy, dx, dy, sc, d, s, rt, lq;
		pixel_t p;
		if (r.req == REQ_LOAD) begin
			sx = longint'($signed(r.data[15:0]));
			sy = longint'($signed(r.data[31:16]));
			dx = longint'($signed(r.data[47:32])) - sx;
			dy = longint'($signed(r.data[63:48])) - sy;
			pos_x = sx <<< FB;
			pos_y = sy <<< FB;
			s = dx * dx + dy * dy;
			rt = root_floor(s);
			if (rt * rt < s) rt++;
			lq = (s == 0) ? 1 : root_floor(s << (2 * LEN_FRAC));
			inc_x = (s == 0) ? 0 : incr_of(dx, lq);
			inc_y = (s == 0) ? 0 : incr_of(dy, lq);
			for (int c = 0; c < 3; c++) begin
				sc = longint'(r.data[64 + 8 * c +: 8]);
				d = longint'(r.data[88 + 8 * c +: 8]) - sc;
				acc_c[c] = sc << FB;
				inc_c[c] = (s == 0) ? 0 : incr_of(d, lq);
			end
			steps_rem = rt;
		end else if (steps_rem != 0) begin
			p.px = 16'(pos_x >= 0 ? pos_x >>> FB : -((-pos_x) >>> FB));
			p.py = 16'(pos_y >= 0 ? pos_y >>> FB : -((-pos_y) >>> FB));
			p.vis = pos_x >= 0 && pos_x < (longint'(SCR_W) << FB) &&
				pos_y >= 0 && pos_y < (longint'(SCR_H) << FB);
			p.color = {clamp_chan(acc_c[0]), clamp_chan(acc_c[1]), clamp_chan(acc_c[2])};
			p.last = steps_rem == 1;
			expected_pixels.push_back(p);
			pos_x += inc_x;
			pos_y += inc_y;
			for (int c = 0; c < 3; c++) acc_c[c] += inc_c[c];
			steps_rem--;
		end
	endtask

	function automatic line_req_t make_load(int sx, int sy, int ex, int ey,
			logic [23:0] c0, logic [23:0] c1);
		line_req_t r;
		r.req = REQ_LOAD;
		r.data = {c1[7:0], c1[15:8], c1[23:16], c0[7:0], c0[15:8], c0[23:16],
			16'(ey), 16'(ex), 16'(sy), 16'(sx)};
		return r;
	endfunction

	function automatic line_req_t make_step();
		line_req_t r;
		r.req = REQ_STEP;
		r.data = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
		return r;
	endfunction

	function automatic int rnd_coord(bit wide);
		if (wide) return int'($signed(16'($urandom)));
		return $urandom_range(0, 60) - 20 + (($urandom_range(0, 3) == 0) ? 1000 : 0);
	endfunction

	always @(posedge clk) begin
		calm <= pending_reqs.size() > 700 && pending_reqs.size() < 900;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_pixel({s_axis_tuser, s_axis_tdata});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
					line_req_t r;
					r = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= r.req;
					s_axis_tdata <= r.data;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				pixel_t got, want;
				got.px = m_axis_tdata[15:0];
				got.py = m_axis_tdata[31:16];
				got.color = m_axis_tdata[55:32];
				got.vis = m_axis_tuser;
				got.last = m_axis_tlast;
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected pixel %h", $time, got);
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: pixel mismatch expected x=%h y=%h vis=%b c=%h last=%b",
							$time, want.px, want.py, want.vis, want.color, want.last);
						$display("%0t:                 actual x=%h y=%h vis=%b c=%h last=%b",
							$time, got.px, got.py, got.vis, got.color, got.last);
					end
				end
			end
			m_axis_tready <= calm || $urandom_range(0, 99) >= 16;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IDLE_LIMIT) begin
			$display("** dda_line_color_interpolator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int n, sx, sy, len;
		bit wide;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_load(5, 5, 5, 5, 24'h102030, 24'h405060));
		pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_load(-3, -2, 4, 3, 24'h00ff00, 24'hff00ff));
		for (int i = 0; i < 6; i++) pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_load(1020, 1020, 1027, 1027, 24'hffffff, 24'h000000));
		for (int i = 0; i < 11; i++) pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_load(-32768, 32767, 32767, -32768, 24'h0, 24'hffffff));
		pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_load(-5, 0, -1, 0, 24'h80ff01, 24'h7f00fe));
		pending_reqs.push_back(make_step());
		pending_reqs.push_back(make_load(0, 0, 3, 0, 24'h0, 24'h0));
		for (int i = 0; i < 4; i++) pending_reqs.push_back(make_step());

		n = pending_reqs.size();
		while (n < 1700) begin
			wide = $urandom_range(0, 9) == 0;
			sx = rnd_coord(wide);
			sy = rnd_coord(wide);
			pending_reqs.push_back(make_load(sx, sy,
				wide ? rnd_coord(1) : sx + $urandom_range(0, 40) - 20,
				wide ? rnd_coord(1) : sy + $urandom_range(0, 40) - 20,
				24'($urandom), 24'($urandom)));
			len = $urandom_range(0, 45);
			for (int i = 0; i < len; i++) pending_reqs.push_back(make_step());
			n += len + 1;
		end

		while (!(pending_reqs.size() == 0 && !s_axis_tvalid && expected_pixels.size() == 0))
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("** dda_line_color_interpolator_top: PASSED **");
		else
			$display("** dda_line_color_interpolator_top: FAILED **");
		$finish;
	end
endmodule
